FILE: hdl/rbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbt_pkg
// Shared constants, command word type and helpers for the receive bitmap
// tracker.
// ----------------------------------------------------------------------------
package rbt_pkg;

   localparam int CAP_BITS    = 16384;
   localparam int ROW_BITS    = 64;
   localparam int OFF_W       = $clog2(ROW_BITS);
   localparam int ROWS        = CAP_BITS / ROW_BITS;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int STORE_BYTES = (CAP_BITS + 7) / 8;
   localparam int IDX_W       = 14;
   localparam int SIZE_W      = 15;
   localparam int POS_W       = 11;
   localparam int LANE_W      = 3;
   localparam int MODE_W      = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request modes, also used as back-end operation codes
   localparam logic [MODE_W-1:0] OP_WRITE  = 3'd0;
   localparam logic [MODE_W-1:0] OP_QUERY  = 3'd1;
   localparam logic [MODE_W-1:0] OP_FIND   = 3'd2;
   localparam logic [MODE_W-1:0] OP_REWIND = 3'd3;
   localparam logic [MODE_W-1:0] OP_CLEAR  = 3'd4;
   localparam logic [MODE_W-1:0] OP_MERGE  = 3'd5;
   localparam logic [MODE_W-1:0] OP_NOP    = 3'd6;

   localparam logic [2:0] NIBBLE_ONES [16] = '{
      3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
      3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
   };

   typedef struct packed {
      logic [MODE_W-1:0] op;
      logic              oor;
      logic [IDX_W-1:0]  bit_index;
      logic              bit_value;
      logic [POS_W-1:0]  byte_position;
      logic [7:0]        merge_byte;
   } cmd_type;

   function automatic logic [3:0] ones_in_byte(input logic [7:0] b);
      return 4'(NIBBLE_ONES[b[3:0]]) + 4'(NIBBLE_ONES[b[7:4]]);
   endfunction

   // larger of declared and grown size, saturated at capacity
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] declared,
                                                  input logic [SIZE_W-1:0] grown);
      logic [SIZE_W-1:0] s;
      s = (declared > grown) ? declared : grown;
      if (32'(s) > CAP_BITS) begin
         s = SIZE_W'(CAP_BITS);
      end
      return s;
   endfunction

endpackage

FILE: hdl/rbt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbt_front
// Request front end: accepts request words, range-checks them and turns
// them into back-end commands pushed into the command queue.
// ----------------------------------------------------------------------------
module rbt_front
   import rbt_pkg::*;
(
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [IDX_W-1:0]  req_bit_index,
   input  logic              req_bit_value,
   input  logic [POS_W-1:0]  req_byte_position,
   input  logic [7:0]        req_merge_byte,
   input  logic              q_full,
   output logic              q_push,
   output cmd_type           q_cmd
);

   logic idx_oor;
   logic pos_oor;

   assign idx_oor   = 32'(req_bit_index) >= CAP_BITS;
   assign pos_oor   = 32'(req_byte_position) >= STORE_BYTES;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd               = '0;
      q_cmd.bit_index     = req_bit_index;
      q_cmd.bit_value     = req_bit_value;
      q_cmd.byte_position = req_byte_position;
      q_cmd.merge_byte    = req_merge_byte;
      case (req_mode)
         OP_WRITE, OP_QUERY: begin
            // out-of-range index: report only
            q_cmd.oor = idx_oor;
            q_cmd.op  = idx_oor ? OP_NOP : req_mode;
         end
         OP_MERGE: begin
            q_cmd.oor = pos_oor;
            q_cmd.op  = pos_oor ? OP_NOP : OP_MERGE;
         end
         OP_FIND, OP_REWIND, OP_CLEAR: begin
            q_cmd.op = req_mode;
         end
         default: begin
            q_cmd.op = OP_NOP;
         end
      endcase
   end

endmodule

FILE: hdl/rbt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbt_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rbt_queue
   import rbt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (32'(count_ff) == QUEUE_DEPTH);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hdl/rbt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbt_back
// Back end: owns the bit store (64-bit rows with per-row valid bits), the
// set-bit count, scan pointer and grown size, executes one command at a time
// and holds the result word until the receiver takes it.
// ----------------------------------------------------------------------------
module rbt_back
   import rbt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SIZE_W-1:0] declared_bits,
   input  logic              q_valid,
   input  cmd_type           q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SIZE_W-1:0] rsp_ones_count,
   output logic              rsp_bit_before,
   output logic              rsp_found,
   output logic [IDX_W-1:0]  rsp_found_index,
   output logic              rsp_out_of_range,
   output logic [SIZE_W-1:0] rsp_size_now
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RMW  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]          state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [SIZE_W-1:0]   count_ff, count_in;
   logic [SIZE_W-1:0]   sp_ff, sp_in;
   logic [SIZE_W-1:0]   grown_ff, grown_in;
   logic [ROWS-1:0]     row_valid_ff, row_valid_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                rsp_before_ff, rsp_before_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                rsp_oor_ff, rsp_oor_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;

   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic [ROW_W-1:0]    rd_row_ff;
   logic                rd_en;
   logic [ROW_W-1:0]    rd_addr;
   logic                wr_en;
   logic [ROW_BITS-1:0] wr_data;

   logic                slot_free;
   logic [SIZE_W-1:0]   size;
   logic [ROW_BITS-1:0] row;
   logic                done;
   logic                r_before;
   logic                r_found;
   logic [IDX_W-1:0]    r_index;
   logic                r_oor;

   logic [OFF_W-1:0]    bit_off;
   logic                old_bit;
   logic [LANE_W-1:0]   lane;
   logic [7:0]          old_byte;
   logic [7:0]          keep;
   logic [7:0]          add_bits;
   logic [SIZE_W-1:0]   first_bit;
   logic [SIZE_W-1:0]   size_left;
   logic [ROW_BITS-1:0] cand;
   logic [ROW_BITS-1:0] lo_mask;
   logic [ROW_BITS-1:0] hi_mask;
   logic [ROW_BITS-1:0] hits;
   logic [IDX_W-1:0]    hit_index;
   logic [SIZE_W-1:0]   next_start;

   function automatic logic [OFF_W-1:0] first_one(input logic [ROW_BITS-1:0] v);
      logic [OFF_W-1:0] r;
      r = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = OFF_W'(i);
         end
      end
      return r;
   endfunction

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign size      = eff_size(declared_bits, grown_ff);
   // a row never written since reset or clear reads as zero
   assign row       = row_valid_ff[rd_row_ff] ? rd_data_ff : '0;

   // scan window: at or above the pointer, below the size
   assign cand      = cmd_ff.bit_value ? row : ~row;
   assign lo_mask   = {ROW_BITS{1'b1}} << sp_ff[OFF_W-1:0];
   always_comb begin
      if ({1'b0, rd_row_ff} < size[SIZE_W-1:OFF_W]) begin
         hi_mask = '1;
      end else if ({1'b0, rd_row_ff} == size[SIZE_W-1:OFF_W]) begin
         hi_mask = ~({ROW_BITS{1'b1}} << size[OFF_W-1:0]);
      end else begin
         hi_mask = '0;
      end
   end
   assign hits       = cand & lo_mask & hi_mask;
   assign hit_index  = {rd_row_ff, first_one(hits)};
   assign next_start = SIZE_W'({rd_row_ff, OFF_W'(0)}) + SIZE_W'(ROW_BITS);

   // merge byte lane
   assign lane      = cmd_ff.byte_position[LANE_W-1:0];
   assign old_byte  = row[8*lane +: 8];
   assign first_bit = SIZE_W'({cmd_ff.byte_position, 3'b000});
   assign size_left = size - first_bit;
   always_comb begin
      if (first_bit >= size) begin
         keep = '0;
      end else if (size_left >= SIZE_W'(8)) begin
         keep = 8'hFF;
      end else begin
         keep = (8'd1 << size_left[2:0]) - 8'd1;
      end
   end
   assign add_bits = cmd_ff.merge_byte & keep & ~old_byte;

   assign bit_off = cmd_ff.bit_index[OFF_W-1:0];
   assign old_bit = row[bit_off];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      sp_in        = sp_ff;
      grown_in     = grown_ff;
      row_valid_in = row_valid_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = rd_row_ff;
      wr_en        = 1'b0;
      wr_data      = row;
      done         = 1'b0;
      r_before     = 1'b0;
      r_found      = 1'b0;
      r_index      = '0;
      r_oor        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               case (q_cmd.op)
                  OP_WRITE, OP_QUERY: begin
                     rd_en    = 1'b1;
                     rd_addr  = q_cmd.bit_index[IDX_W-1:OFF_W];
                     state_in = S_RMW;
                  end
                  OP_MERGE: begin
                     rd_en    = 1'b1;
                     rd_addr  = q_cmd.byte_position[POS_W-1:LANE_W];
                     state_in = S_RMW;
                  end
                  OP_FIND: begin
                     if (sp_ff >= size) begin
                        done = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = sp_ff[IDX_W-1:OFF_W];
                        state_in = S_SCAN;
                     end
                  end
                  OP_REWIND: begin
                     sp_in = '0;
                     done  = 1'b1;
                  end
                  OP_CLEAR: begin
                     row_valid_in = '0;
                     count_in     = '0;
                     done         = 1'b1;
                  end
                  default: begin
                     r_oor = q_cmd.oor;
                     done  = 1'b1;
                  end
               endcase
            end
         end
         S_RMW: begin
            state_in = S_IDLE;
            done     = 1'b1;
            case (cmd_ff.op)
               OP_WRITE: begin
                  r_before         = old_bit;
                  wr_en            = 1'b1;
                  wr_data[bit_off] = cmd_ff.bit_value;
                  if (cmd_ff.bit_value && !old_bit) begin
                     count_in = count_ff + 1'b1;
                  end else if (!cmd_ff.bit_value && old_bit) begin
                     count_in = count_ff - 1'b1;
                  end
                  if (SIZE_W'(cmd_ff.bit_index) >= size) begin
                     grown_in = SIZE_W'(cmd_ff.bit_index) + 1'b1;
                  end
               end
               OP_QUERY: begin
                  r_before = old_bit;
               end
               OP_MERGE: begin
                  wr_en                = 1'b1;
                  wr_data[8*lane +: 8] = old_byte | add_bits;
                  count_in             = count_ff + SIZE_W'(ones_in_byte(add_bits));
               end
               default: begin
               end
            endcase
            if (wr_en) begin
               row_valid_in[rd_row_ff] = 1'b1;
            end
         end
         S_SCAN: begin
            if (hits != '0) begin
               r_found  = 1'b1;
               r_index  = hit_index;
               sp_in    = SIZE_W'(hit_index) + 1'b1;
               done     = 1'b1;
               state_in = S_IDLE;
            end else if (next_start >= size) begin
               sp_in    = size;
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               // advance to the next row
               sp_in   = next_start;
               rd_en   = 1'b1;
               rd_addr = rd_row_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hold the result word until taken, load a new one when done
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_count_in  = rsp_count_ff;
      rsp_before_in = rsp_before_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_oor_in    = rsp_oor_ff;
      rsp_size_in   = rsp_size_ff;
      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_count_in  = count_in;
         rsp_before_in = r_before;
         rsp_found_in  = r_found;
         rsp_index_in  = r_index;
         rsp_oor_in    = r_oor;
         rsp_size_in   = eff_size(declared_bits, grown_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sp_ff        <= '0;
         grown_ff     <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         grown_ff     <= grown_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_before_ff <= rsp_before_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_oor_ff    <= rsp_oor_in;
      rsp_size_ff   <= rsp_size_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[rd_row_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_row_ff  <= rd_addr;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ones_count   = rsp_count_ff;
   assign rsp_bit_before   = rsp_before_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_found_index  = rsp_index_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_size_now     = rsp_size_ff;

endmodule

FILE: hdl/receive_bitmap_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receive_bitmap_tracker
// Arrival bitmap with running set-bit count, find-next scan and byte merge.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (req_*) carry a mode and its operands; each request yields
//   exactly one response word (rsp_*) in order. csr_wr_en/csr_wr_data write
//   the declared size; write it only while no request is in flight.
//   A request moves when valid is high and stall is low on its channel.
//   Requests enter a 2-deep command queue one per cycle while it is not
//   full; the executor runs one command at a time from it:
//     rewind, clear all, unknown modes, out-of-range: answered from idle
//     write, query, merge: row read, then modify and write back
//     find next: row reads, one 64-bit store row per cycle
//   A queued command waits for those ahead of it in the queue.
//   Reset clears the count, scan pointer, grown size, declared size and all
//   row valid bits, so the store reads as zero at once with no clearing pass.
//   A stalled response holds in its register; the executor waits for it to
//   drain, and req_stall rises once the command queue fills.
// ----------------------------------------------------------------------------
module receive_bitmap_tracker
   import rbt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [IDX_W-1:0]  req_bit_index,
   input  logic              req_bit_value,
   input  logic [POS_W-1:0]  req_byte_position,
   input  logic [7:0]        req_merge_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SIZE_W-1:0] rsp_ones_count,
   output logic              rsp_bit_before,
   output logic              rsp_found,
   output logic [IDX_W-1:0]  rsp_found_index,
   output logic              rsp_out_of_range,
   output logic [SIZE_W-1:0] rsp_size_now
);

   logic [SIZE_W-1:0] declared_ff, declared_in;
   logic              q_full;
   logic              q_push;
   cmd_type           push_cmd;
   logic              q_pop;
   logic              head_valid;
   cmd_type           head_cmd;

   assign declared_in = csr_wr_en ? csr_wr_data : declared_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         declared_ff <= '0;
      end else begin
         declared_ff <= declared_in;
      end
   end

   rbt_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_bit_index     (req_bit_index),
      .req_bit_value     (req_bit_value),
      .req_byte_position (req_byte_position),
      .req_merge_byte    (req_merge_byte),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_cmd             (push_cmd)
   );

   rbt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   rbt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .declared_bits    (declared_ff),
      .q_valid          (head_valid),
      .q_cmd            (head_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ones_count   (rsp_ones_count),
      .rsp_bit_before   (rsp_bit_before),
      .rsp_found        (rsp_found),
      .rsp_found_index  (rsp_found_index),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_size_now     (rsp_size_now)
   );

endmodule

FILE: tb/receive_bitmap_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receive_bitmap_tracker_tb
// Self-checking bench for the receive bitmap tracker. A queue of request
// words fills in phases, each under its own declared size. A clocked driver
// offers the words, and a clocked monitor compares each response word field
// by field with a bit-level copy of the tracker kept inside the bench.
// Both sides insert random gaps. One long response hold-off fills the block
// so that it stalls its input.
// ----------------------------------------------------------------------------
module receive_bitmap_tracker_tb;
   import rbt_pkg::*;

   localparam logic [MODE_W-1:0] OP_SPARE   = 3'd7;
   localparam int                HOLD_LEN   = 60;
   localparam int                QUIET_MAX  = 2000;
   localparam int                MAX_INDEX  = CAP_BITS - 1;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  bit_index;
      logic              bit_value;
      logic [POS_W-1:0]  byte_position;
      logic [7:0]        merge_byte;
   } request_type;

   typedef struct packed {
      logic [SIZE_W-1:0] ones_count;
      logic              bit_before;
      logic              found;
      logic [IDX_W-1:0]  found_index;
      logic              out_of_range;
      logic [SIZE_W-1:0] size_now;
   } status_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [SIZE_W-1:0] csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [MODE_W-1:0] req_mode = '0;
   logic [IDX_W-1:0]  req_bit_index = '0;
   logic              req_bit_value = 1'b0;
   logic [POS_W-1:0]  req_byte_position = '0;
   logic [7:0]        req_merge_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [SIZE_W-1:0] rsp_ones_count;
   logic              rsp_bit_before;
   logic              rsp_found;
   logic [IDX_W-1:0]  rsp_found_index;
   logic              rsp_out_of_range;
   logic [SIZE_W-1:0] rsp_size_now;

   // bench copy of the tracker state
   bit          arrived [CAP_BITS];
   int unsigned arrived_total = 0;
   int unsigned scan_at = 0;
   int unsigned grown_to = 0;
   int unsigned declared_to = 0;

   request_type pending_words [$];
   status_type  status_due [$];
   int unsigned words_queued = 0;
   int unsigned words_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned holds_asked = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned send_gap = 0;
   int unsigned drain_wait = 0;
   int unsigned quiet_cycles = 0;
   bit          idling_on = 1'b1;
   request_type next_word;

   receive_bitmap_tracker dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_bit_index     (req_bit_index),
      .req_bit_value     (req_bit_value),
      .req_byte_position (req_byte_position),
      .req_merge_byte    (req_merge_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ones_count    (rsp_ones_count),
      .rsp_bit_before    (rsp_bit_before),
      .rsp_found         (rsp_found),
      .rsp_found_index   (rsp_found_index),
      .rsp_out_of_range  (rsp_out_of_range),
      .rsp_size_now      (rsp_size_now)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned tracked_size();
      int unsigned s;
      s = (declared_to > grown_to) ? declared_to : grown_to;
      return (s > CAP_BITS) ? CAP_BITS : s;
   endfunction

   // apply one request word to the bench copy and return the status it yields
   function automatic status_type track_request(request_type w);
      status_type  s;
      int unsigned size;
      int unsigned p;
      s = '0;
      size = tracked_size();
      case (w.mode)
         OP_WRITE, OP_QUERY: begin
            if (w.bit_index >= CAP_BITS) begin
               s.out_of_range = 1'b1;
            end else begin
               s.bit_before = arrived[w.bit_index];
               if (w.mode == OP_WRITE) begin
                  if (w.bit_index >= size) begin
                     grown_to = w.bit_index + 1;
                  end
                  if (w.bit_value && !arrived[w.bit_index]) begin
                     arrived_total++;
                  end
                  if (!w.bit_value && arrived[w.bit_index]) begin
                     arrived_total--;
                  end
                  arrived[w.bit_index] = w.bit_value;
               end
            end
         end
         OP_FIND: begin
            while (scan_at < size && !s.found) begin
               if (arrived[scan_at] == w.bit_value) begin
                  s.found = 1'b1;
                  s.found_index = IDX_W'(scan_at);
               end
               scan_at++;
            end
         end
         OP_REWIND: begin
            scan_at = 0;
         end
         OP_CLEAR: begin
            arrived = '{default: 1'b0};
            arrived_total = 0;
         end
         OP_MERGE: begin
            if (w.byte_position >= STORE_BYTES) begin
               s.out_of_range = 1'b1;
            end else begin
               // drop source bits at or above the effective size
               for (int b = 0; b < 8; b++) begin
                  p = w.byte_position * 8 + b;
                  if (w.merge_byte[b] && p < size && !arrived[p]) begin
                     arrived[p] = 1'b1;
                     arrived_total++;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      s.ones_count = SIZE_W'(arrived_total);
      s.size_now = SIZE_W'(tracked_size());
      return s;
   endfunction

   function automatic int unsigned draw_gap();
      if (!idling_on || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
   endtask

   task automatic check_status(status_type want);
      if (rsp_ones_count !== want.ones_count) begin
         report_field("ones_count", 32'(want.ones_count), 32'(rsp_ones_count));
      end
      if (rsp_bit_before !== want.bit_before) begin
         report_field("bit_before", 32'(want.bit_before), 32'(rsp_bit_before));
      end
      if (rsp_found !== want.found) begin
         report_field("found", 32'(want.found), 32'(rsp_found));
      end
      if (rsp_found_index !== want.found_index) begin
         report_field("found_index", 32'(want.found_index), 32'(rsp_found_index));
      end
      if (rsp_out_of_range !== want.out_of_range) begin
         report_field("out_of_range", 32'(want.out_of_range), 32'(rsp_out_of_range));
      end
      if (rsp_size_now !== want.size_now) begin
         report_field("size_now", 32'(want.size_now), 32'(rsp_size_now));
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            status_due.push_back(track_request({req_mode, req_bit_index, req_bit_value,
                                                req_byte_position, req_merge_byte}));
            send_gap = draw_gap();
         end
         if (!req_valid || !req_stall) begin
            if (send_gap == 0 && pending_words.size() != 0) begin
               next_word = pending_words.pop_front();
               req_valid <= 1'b1;
               req_mode <= next_word.mode;
               req_bit_index <= next_word.bit_index;
               req_bit_value <= next_word.bit_value;
               req_byte_position <= next_word.byte_position;
               req_merge_byte <= next_word.merge_byte;
            end else begin
               req_valid <= 1'b0;
               if (send_gap != 0) begin
                  send_gap--;
               end
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         drain_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response word, expected none actual ones_count %0d",
                        $time, rsp_ones_count);
            end else begin
               check_status(status_due.pop_front());
               words_checked++;
            end
            drain_wait = draw_gap();
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_LEN - 1;
            rsp_stall <= 1'b1;
         end else if (drain_wait != 0) begin
            drain_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_MAX) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer(logic [MODE_W-1:0] mode, int unsigned idx, int unsigned val,
                        int unsigned pos, int unsigned mb);
      request_type w;
      w.mode = mode;
      w.bit_index = IDX_W'(idx);
      w.bit_value = val[0];
      w.byte_position = POS_W'(pos);
      w.merge_byte = 8'(mb);
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic wait_idle();
      while (words_checked != words_queued) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_declared(int unsigned bits);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= SIZE_W'(bits);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      declared_to = bits & 32'h7fff;
      @(posedge clock);
   endtask

   // one short run of related words: scans, write bursts, merges, reads or noise
   task automatic offer_burst();
      int unsigned kind;
      int unsigned hi;
      int unsigned v;
      int unsigned n;
      hi = tracked_size() + 4;
      if (hi > MAX_INDEX) begin
         hi = MAX_INDEX;
      end
      kind = $urandom_range(0, 19);
      n = $urandom_range(2, 8);
      if (kind <= 4) begin
         if ($urandom_range(0, 3) != 0) begin
            offer(OP_REWIND, $urandom, $urandom, $urandom, $urandom);
         end
         v = $urandom_range(0, 1);
         repeat (n) begin
            offer(OP_FIND, $urandom, ($urandom_range(0, 4) == 0) ? 32'(!v) : v,
                  $urandom, $urandom);
         end
      end else if (kind <= 10) begin
         repeat (n + 2) begin
            offer(OP_WRITE, $urandom_range(0, hi), 32'($urandom_range(0, 2) != 0),
                  $urandom, $urandom);
         end
      end else if (kind <= 13) begin
         repeat (n / 2 + 1) begin
            offer(OP_MERGE, $urandom, $urandom,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, STORE_BYTES - 1)
                                              : $urandom_range(0, hi / 8),
                  $urandom);
         end
      end else if (kind <= 16) begin
         repeat (n / 2 + 1) begin
            offer(OP_QUERY, ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_INDEX)
                                                        : $urandom_range(0, hi),
                  $urandom, $urandom, $urandom);
         end
      end else begin
         case ($urandom_range(0, 3))
            0: offer(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
            1: offer(OP_NOP, $urandom, $urandom, $urandom, $urandom);
            2: offer(OP_SPARE, $urandom, $urandom, $urandom, $urandom);
            default: offer(OP_REWIND, $urandom, $urandom, $urandom, $urandom);
         endcase
      end
   endtask

   task automatic run_phase(int unsigned bits, int unsigned count, bit gaps, bit long_hold);
      int unsigned goal;
      set_declared(bits);
      idling_on <= gaps;
      if (long_hold) begin
         holds_asked <= holds_asked + 1;
      end
      goal = words_queued + count;
      while (words_queued < goal) begin
         offer_burst();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words against an empty store, declared size zero
      offer(OP_QUERY, 0, 0, 0, 0);
      offer(OP_FIND, 0, 1, 0, 0);
      offer(OP_WRITE, 0, 1, 0, 0);
      offer(OP_WRITE, 5, 1, 0, 0);
      offer(OP_WRITE, 5, 1, 0, 0);
      offer(OP_WRITE, 5, 0, 0, 0);
      offer(OP_QUERY, MAX_INDEX, 1, STORE_BYTES - 1, 32'hff);
      offer(OP_QUERY, 0, 0, 0, 0);
      offer(OP_MERGE, 0, 0, 0, 32'hff);
      offer(OP_MERGE, 0, 0, 1, 32'haa);
      offer(OP_MERGE, 0, 0, STORE_BYTES - 1, 32'hff);
      offer(OP_MERGE, 0, 0, 0, 32'h00);
      offer(OP_REWIND, 0, 0, 0, 0);
      offer(OP_FIND, 0, 0, 0, 0);
      offer(OP_FIND, 0, 1, 0, 0);
      offer(OP_FIND, 0, 1, 0, 0);
      offer(OP_FIND, 0, 1, 0, 0);
      offer(OP_NOP, MAX_INDEX, 1, STORE_BYTES - 1, 32'hff);
      offer(OP_SPARE, 0, 0, 0, 0);
      offer(OP_CLEAR, 0, 0, 0, 0);
      offer(OP_WRITE, 10, 0, 0, 0);
      offer(OP_REWIND, 0, 0, 0, 0);
      offer(OP_FIND, 0, 0, 0, 0);
      offer(OP_FIND, 0, 1, 0, 0);

      run_phase(40, 90, 1'b1, 1'b0);
      run_phase(CAP_BITS, 90, 1'b0, 1'b1);
      run_phase(8, 45, 1'b1, 1'b0);
      run_phase(8, 45, 1'b1, 1'b0);
      run_phase(32767, 90, 1'b1, 1'b0);
      run_phase(130, 90, 1'b0, 1'b0);
      run_phase(0, 90, 1'b1, 1'b0);

      // grow to full capacity through the top index
      offer(OP_WRITE, MAX_INDEX, 1, 0, 0);
      offer(OP_QUERY, MAX_INDEX, 0, 0, 0);
      offer(OP_REWIND, 0, 0, 0, 0);
      offer(OP_FIND, 0, 1, 0, 0);
      offer(OP_FIND, 0, 1, 0, 0);
      offer(OP_WRITE, MAX_INDEX, 0, 0, 0);

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: receive_bitmap_tracker.f
hdl/rbt_pkg.sv
hdl/rbt_front.sv
hdl/rbt_queue.sv
hdl/rbt_back.sv
hdl/receive_bitmap_tracker.sv
tb/receive_bitmap_tracker_tb.sv
